>>> sv/bbcd_pkg.sv
// Shared types and constants for the buffer cache directory.
// Request/response word layouts, status codes and default sizes.
// No dependencies.
package bbcd_pkg;

  localparam int unsigned EntriesDef = 64;
  localparam int unsigned RefBitsDef = 8;
  localparam int unsigned WordW      = 32;
  localparam int unsigned SlotW      = 6;
  localparam int unsigned StampW     = 16;
  localparam int unsigned StatusW    = 3;

  localparam logic ModeAcquire = 1'b0;
  localparam logic ModeRelease = 1'b1;

  localparam logic [StatusW-1:0] StHit        = 3'd0;
  localparam logic [StatusW-1:0] StFilled     = 3'd1;
  localparam logic [StatusW-1:0] StZero       = 3'd2;
  localparam logic [StatusW-1:0] StExhausted  = 3'd3;
  localparam logic [StatusW-1:0] StReleased   = 3'd4;
  localparam logic [StatusW-1:0] StBadRelease = 3'd5;
  localparam logic [StatusW-1:0] StCountFull  = 3'd6;

  typedef struct packed {
    logic             mode;
    logic [WordW-1:0] file_id;
    logic [WordW-1:0] block_index;
    logic [WordW-1:0] device_block;
    logic [SlotW-1:0] slot;
  } req_t;

  typedef struct packed {
    logic [StatusW-1:0] status;
    logic [SlotW-1:0]   slot_out;
    logic [WordW-1:0]   stored_device_block;
    logic               evicted;
  } rsp_t;

  // control from the sequencer to the compare unit
  typedef struct packed {
    logic clr;  // start of a new command: forget the victim candidate
    logic chk;  // a directory row is on the read port this cycle
  } cmp_ctl_t;

endpackage

>>> sv/bbcd_cmp.sv
// Shared compare unit: tag match against the row on the read port and
// running choice of the oldest released, unpinned row.
// Depends on bbcd_pkg.
module bbcd_cmp #(
  parameter int unsigned AW       = 6,
  parameter int unsigned REF_BITS = bbcd_pkg::RefBitsDef
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  bbcd_pkg::cmp_ctl_t            ctl_i,
  input  logic [bbcd_pkg::WordW-1:0]    req_file_i,
  input  logic [bbcd_pkg::WordW-1:0]    req_index_i,
  input  logic [bbcd_pkg::WordW-1:0]    row_file_i,
  input  logic [bbcd_pkg::WordW-1:0]    row_index_i,
  input  logic [REF_BITS-1:0]           row_refs_i,
  input  logic [bbcd_pkg::StampW-1:0]   row_stamp_i,
  input  logic [AW-1:0]                 row_addr_i,
  input  logic [bbcd_pkg::StampW-1:0]   rel_clock_i,
  output logic                          match_o,
  output logic                          found_o,
  output logic [AW-1:0]                 best_slot_o
);
  import bbcd_pkg::*;

  logic              found_q, found_d;
  logic [StampW-1:0] best_age_q, best_age_d;
  logic [AW-1:0]     best_slot_q, best_slot_d;
  logic [StampW-1:0] age;
  logic              better;

  assign match_o = ctl_i.chk && (row_file_i == req_file_i) && (row_index_i == req_index_i);

  // age wraps modulo 2^16; strict compare keeps the lowest slot on ties
  assign age    = rel_clock_i - row_stamp_i;
  assign better = ctl_i.chk && (row_refs_i == '0) && (!found_q || (age > best_age_q));

  always_comb begin
    found_d     = found_q;
    best_age_d  = best_age_q;
    best_slot_d = best_slot_q;
    if (ctl_i.clr) begin
      found_d = 1'b0;
    end else if (better) begin
      found_d     = 1'b1;
      best_age_d  = age;
      best_slot_d = row_addr_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      found_q <= 1'b0;
    end else begin
      found_q <= found_d;
    end
  end

  always_ff @(posedge clk_i) begin
    best_age_q  <= best_age_d;
    best_slot_q <= best_slot_d;
  end

  assign found_o     = found_q;
  assign best_slot_o = best_slot_q;

endmodule

>>> sv/block_buffer_cache_directory_core.sv
// Buffer cache directory top level: sequencer, directory memory, result register.
// Depends on bbcd_pkg and bbcd_cmp.
//
// One command at a time: start_i is taken when busy_o is low, and the result
// word shows on rsp_o for exactly one cycle with valid_o high, in the first cycle
// that busy_o is low again; a new command may be started in that same cycle. The
// receiver cannot stall. An acquire walks the filled part of the directory one row
// per cycle through the single read port of the directory memory and one shared
// tag/age compare unit: a hit stops the walk at the matching slot, a miss reads
// every filled slot first. A release reads the row, then updates it unless the
// release is refused.
// Slots fill in ascending order and never go invalid, so validity is a fill
// count and no clearing pass is needed after reset.
module block_buffer_cache_directory_core #(
  parameter int unsigned ENTRIES  = bbcd_pkg::EntriesDef,
  parameter int unsigned REF_BITS = bbcd_pkg::RefBitsDef
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           start_i,
  input  bbcd_pkg::req_t req_i,
  output logic           busy_o,
  output logic           valid_o,
  output bbcd_pkg::rsp_t rsp_o
);
  import bbcd_pkg::*;

  localparam int unsigned AW = $clog2(ENTRIES);
  localparam int unsigned CW = AW + 1;
  localparam int unsigned SW = (CW > SlotW + 1) ? CW : SlotW + 1;
  localparam logic [CW-1:0]       Full   = CW'(ENTRIES);
  localparam logic [REF_BITS-1:0] RefMax = '1;
  localparam logic [REF_BITS-1:0] RefOne = REF_BITS'(1);

  localparam logic [2:0] SIdle   = 3'd0;
  localparam logic [2:0] SScan   = 3'd1;
  localparam logic [2:0] SHit    = 3'd2;
  localparam logic [2:0] SMiss   = 3'd3;
  localparam logic [2:0] SRelRd  = 3'd4;
  localparam logic [2:0] SRelChk = 3'd5;

  typedef struct packed {
    logic [WordW-1:0]    file;
    logic [WordW-1:0]    index;
    logic [WordW-1:0]    dev;
    logic [REF_BITS-1:0] refs;
    logic [StampW-1:0]   stamp;
  } row_t;

  row_t dir_mem [ENTRIES];
  row_t rd_row_q;
  row_t wr_row;
  logic          rd_en, wr_en;
  logic [AW-1:0] rd_addr, wr_addr;

  logic [2:0]        state_q, state_d;
  req_t              req_q;
  logic [CW-1:0]     issue_q, issue_d;
  logic              pend_q, pend_d;
  logic [AW-1:0]     pend_addr_q;
  logic [CW-1:0]     fill_q, fill_d;
  logic [StampW-1:0] rclk_q, rclk_d;
  logic              valid_q, valid_d;
  rsp_t              rsp_q, rsp_d;

  cmp_ctl_t          cmp_ctl;
  logic              match;
  logic              cand_found;
  logic [AW-1:0]     cand_slot;

  logic [SW-1:0]       slot_w;
  logic [AW-1:0]       rel_addr;
  logic                rel_in;
  logic [REF_BITS-1:0] refs_dec;
  logic [AW-1:0]       victim;
  logic                do_fill;

  assign slot_w   = SW'(req_q.slot);
  assign rel_addr = AW'(slot_w);
  assign rel_in   = slot_w < SW'(fill_q);
  assign refs_dec = rd_row_q.refs - RefOne;

  bbcd_cmp #(
    .AW       (AW),
    .REF_BITS (REF_BITS)
  ) u_cmp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .ctl_i       (cmp_ctl),
    .req_file_i  (req_q.file_id),
    .req_index_i (req_q.block_index),
    .row_file_i  (rd_row_q.file),
    .row_index_i (rd_row_q.index),
    .row_refs_i  (rd_row_q.refs),
    .row_stamp_i (rd_row_q.stamp),
    .row_addr_i  (pend_addr_q),
    .rel_clock_i (rclk_q),
    .match_o     (match),
    .found_o     (cand_found),
    .best_slot_o (cand_slot)
  );

  always_comb begin
    state_d = state_q;
    issue_d = issue_q;
    pend_d  = 1'b0;
    fill_d  = fill_q;
    rclk_d  = rclk_q;
    valid_d = 1'b0;
    rsp_d   = rsp_q;
    rd_en   = 1'b0;
    rd_addr = issue_q[AW-1:0];
    wr_en   = 1'b0;
    wr_addr = pend_addr_q;
    wr_row  = rd_row_q;
    cmp_ctl = '0;
    victim  = fill_q[AW-1:0];
    do_fill = 1'b0;

    unique case (state_q)
      SIdle: begin
        if (start_i) begin
          state_d     = (req_i.mode == ModeRelease) ? SRelRd : SScan;
          issue_d     = '0;
          cmp_ctl.clr = 1'b1;
        end
      end

      SScan: begin
        cmp_ctl.chk = pend_q;
        if (pend_q && match) begin
          // stop reading so the matched row stays on the read port
          state_d = SHit;
        end else if (!pend_q && (issue_q == fill_q)) begin
          state_d = SMiss;
        end else if (issue_q != fill_q) begin
          rd_en   = 1'b1;
          rd_addr = issue_q[AW-1:0];
          issue_d = issue_q + CW'(1);
          pend_d  = 1'b1;
        end
      end

      SHit: begin
        state_d                   = SIdle;
        valid_d                   = 1'b1;
        rsp_d                     = '0;
        rsp_d.slot_out            = SlotW'(pend_addr_q);
        rsp_d.stored_device_block = rd_row_q.dev;
        if (rd_row_q.refs == RefMax) begin
          rsp_d.status = StCountFull;
        end else begin
          rsp_d.status = StHit;
          wr_en        = 1'b1;
          wr_addr      = pend_addr_q;
          wr_row.refs  = rd_row_q.refs + RefOne;
        end
      end

      SMiss: begin
        state_d = SIdle;
        valid_d = 1'b1;
        rsp_d   = '0;
        if (req_q.device_block == '0) begin
          rsp_d.status = StZero;
        end else if (fill_q != Full) begin
          victim  = fill_q[AW-1:0];
          fill_d  = fill_q + CW'(1);
          do_fill = 1'b1;
        end else if (cand_found) begin
          victim        = cand_slot;
          rsp_d.evicted = 1'b1;
          do_fill       = 1'b1;
        end else begin
          rsp_d.status = StExhausted;
        end
        if (do_fill) begin
          wr_en                     = 1'b1;
          wr_addr                   = victim;
          wr_row.file               = req_q.file_id;
          wr_row.index              = req_q.block_index;
          wr_row.dev                = req_q.device_block;
          wr_row.refs               = RefOne;
          wr_row.stamp              = '0;
          rsp_d.status              = StFilled;
          rsp_d.slot_out            = SlotW'(victim);
          rsp_d.stored_device_block = req_q.device_block;
        end
      end

      SRelRd: begin
        rd_en   = 1'b1;
        rd_addr = rel_addr;
        state_d = SRelChk;
      end

      SRelChk: begin
        state_d = SIdle;
        valid_d = 1'b1;
        rsp_d   = '0;
        if (!rel_in || (rd_row_q.refs == '0)) begin
          rsp_d.status = StBadRelease;
        end else begin
          wr_en       = 1'b1;
          wr_addr     = rel_addr;
          wr_row.refs = refs_dec;
          if (refs_dec == '0) begin
            // entry becomes reusable: stamp it with the release order
            wr_row.stamp = rclk_q;
            rclk_d       = rclk_q + StampW'(1);
          end
          rsp_d.status              = StReleased;
          rsp_d.slot_out            = req_q.slot;
          rsp_d.stored_device_block = rd_row_q.dev;
        end
      end

      default: begin
        state_d = SIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      dir_mem[wr_addr] <= wr_row;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en) begin
      rd_row_q <= dir_mem[rd_addr];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= SIdle;
      issue_q <= '0;
      pend_q  <= 1'b0;
      fill_q  <= '0;
      rclk_q  <= '0;
      valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      issue_q <= issue_d;
      pend_q  <= pend_d;
      fill_q  <= fill_d;
      rclk_q  <= rclk_d;
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if ((state_q == SIdle) && start_i) begin
      req_q <= req_i;
    end
    if (rd_en) begin
      pend_addr_q <= rd_addr;
    end
    rsp_q <= rsp_d;
  end

  assign busy_o  = (state_q != SIdle);
  assign valid_o = valid_q;
  assign rsp_o   = rsp_q;

`ifndef SYNTHESIS
  a_valid_after_work: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_q |-> ($past(state_q) == SHit || $past(state_q) == SMiss ||
                 $past(state_q) == SRelChk))
    else $error("result word without a finishing step");

  a_fill_monotonic: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fill_q >= $past(fill_q)) && (fill_q <= Full))
    else $error("fill count went backwards or past capacity");

  a_evict_only_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_q && rsp_q.evicted) |-> (rsp_q.status == StFilled && fill_q == Full))
    else $error("eviction reported while free slots remain");

  a_scan_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pend_q |-> (CW'(pend_addr_q) < fill_q))
    else $error("scan read beyond filled slots");
`endif

endmodule
